### rtl/pie_pkg.sv
// Shared widths, error codes and character codes for the postfix evaluator.
package pie_pkg;

	localparam int DATA_W          = 32;
	localparam int CHAR_W          = 8;
	localparam int ERR_W           = 2;
	localparam int STACK_DEPTH_DEF = 16;

	typedef logic [DATA_W-1:0] word_t;
	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [ERR_W-1:0]  err_t;

	localparam err_t ERR_NONE  = 2'd0;
	localparam err_t ERR_UNDER = 2'd1;
	localparam err_t ERR_OVER  = 2'd2;
	localparam err_t ERR_DIVZ  = 2'd3;

	localparam char_t CH_NL    = 8'h0A;
	localparam char_t CH_SP    = 8'h20;
	localparam char_t CH_PLUS  = 8'h2B;
	localparam char_t CH_MINUS = 8'h2D;
	localparam char_t CH_MUL   = 8'h2A;
	localparam char_t CH_DIV   = 8'h2F;
	localparam char_t CH_MOD   = 8'h25;
	localparam char_t CH_XOR   = 8'h5E;
	localparam char_t CH_OR    = 8'h7C;
	localparam char_t CH_AND   = 8'h26;
	localparam char_t CH_ZERO  = 8'h30;

endpackage

### rtl/pie_if.sv
// Valid/ready channel interfaces for characters in and results out.
interface pie_char_if;
	logic           valid;
	logic           ready;
	pie_pkg::char_t char_code;

	modport source (output valid, output char_code, input ready);
	modport sink   (input valid, input char_code, output ready);
endinterface

interface pie_result_if;
	logic                              valid;
	logic                              ready;
	logic signed [pie_pkg::DATA_W-1:0] result_value;
	pie_pkg::err_t                     error_code;

	modport source (output valid, output result_value, output error_code, input ready);
	modport sink   (input valid, input result_value, input error_code, output ready);
endinterface

### rtl/postfix_integer_evaluator_core.sv
// Postfix integer evaluator: character parser, operand stack in RAM, sequencer and divider.
//
// Usage
//   chars   : one ASCII character per beat (valid/ready). Tokens are separated by spaces;
//             + - * / % ^ | & pop two operands and push the result, a newline pops the
//             top of stack and sends it out on results.
//   results : one beat per newline, carrying the popped value and the first error seen
//             since the previous result (none, underflow, overflow, divide by zero).
// Timing
//   Digits, spaces and signs are taken without a stall; chars.ready stays high.
//   A newline does a stack read, then a load of the output register.
//   An operator does two stack reads through the single RAM read port,
//   then executes and writes back. / and % also wait for the bit-serial divider.
//   The worst case per character is set by the divider loop.
// Reset
//   arst_n clears the stack pointer, parser state and sticky error; the stack RAM keeps
//   its contents, which are never read before being pushed.
// Back-pressure
//   Results sit in an output register; characters keep being taken while it waits.
//   Only a second newline stalls, in its load cycle, until the held beat is taken.
module postfix_integer_evaluator_core #(
	parameter int STACK_DEPTH = pie_pkg::STACK_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	pie_char_if.sink            chars,
	pie_result_if.source        results
);

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W = $clog2(STACK_DEPTH);

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_GETB = 3'd1;
	localparam logic [2:0] S_GETA = 3'd2;
	localparam logic [2:0] S_EXEC = 3'd3;
	localparam logic [2:0] S_DIVW = 3'd4;
	localparam logic [2:0] S_EMIT = 3'd5;

	// parser modes
	localparam logic [1:0] M_IDLE   = 2'd0;
	localparam logic [1:0] M_MINUS  = 2'd1;
	localparam logic [1:0] M_NUMBER = 2'd2;

	logic [2:0]       state_q;
	logic [1:0]       mode_q;
	logic             neg_q;
	pie_pkg::word_t   accum_q;
	logic [CNT_W-1:0] count_q;
	pie_pkg::err_t    sticky_q;
	pie_pkg::char_t   op_q;
	logic             popped_q;
	pie_pkg::word_t   a_q;
	pie_pkg::word_t   b_q;

	logic             out_valid_q;
	pie_pkg::word_t   out_value_q;
	pie_pkg::err_t    out_err_q;

	// operand stack: one write and one read port, registered read data
	pie_pkg::word_t   store_mem [STACK_DEPTH];
	pie_pkg::word_t   rd_data_q;
	logic             rd_en;
	logic             wr_en;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] wr_addr;
	logic [CNT_W-1:0] count_dec;

	logic             accept;
	pie_pkg::char_t   c;
	logic             is_op;
	logic             is_sp;
	logic             is_nl;
	logic             stack_empty;
	logic             stack_full;
	logic             pop_req;
	logic             push_req;
	pie_pkg::word_t   push_val;
	pie_pkg::err_t    note_code;
	logic             emit_load;
	pie_pkg::word_t   digit;
	pie_pkg::word_t   accum_next;
	pie_pkg::word_t   alu_res;
	logic             is_divop;
	logic             div_start;
	logic             div_done;
	pie_pkg::word_t   div_q;
	pie_pkg::word_t   div_r;
	pie_pkg::word_t   div_res;
	pie_pkg::word_t   mag_a;
	pie_pkg::word_t   mag_b;

	assign chars.ready = (state_q == S_IDLE);
	assign accept      = chars.valid && chars.ready;
	assign c           = chars.char_code;
	assign is_sp       = (c == pie_pkg::CH_SP);
	assign is_nl       = (c == pie_pkg::CH_NL);
	assign is_op       = (c == pie_pkg::CH_PLUS) || (c == pie_pkg::CH_MUL) ||
	                     (c == pie_pkg::CH_DIV)  || (c == pie_pkg::CH_MOD) ||
	                     (c == pie_pkg::CH_XOR)  || (c == pie_pkg::CH_OR)  ||
	                     (c == pie_pkg::CH_AND);

	assign stack_empty = (count_q == '0);
	assign stack_full  = (count_q == CNT_W'(STACK_DEPTH));
	assign count_dec   = count_q - 1'b1;

	// decimal accumulate: accum*10 + (c - '0'), wrapping
	assign digit      = {{(pie_pkg::DATA_W-pie_pkg::CHAR_W){1'b0}}, c} -
	                    {{(pie_pkg::DATA_W-pie_pkg::CHAR_W){1'b0}}, pie_pkg::CH_ZERO};
	assign accum_next = (accum_q << 3) + (accum_q << 1) + digit;

	assign is_divop = (op_q == pie_pkg::CH_DIV) || (op_q == pie_pkg::CH_MOD);
	assign mag_a    = a_q[pie_pkg::DATA_W-1] ? (pie_pkg::word_t'(0) - a_q) : a_q;
	assign mag_b    = b_q[pie_pkg::DATA_W-1] ? (pie_pkg::word_t'(0) - b_q) : b_q;

	always_comb begin
		unique case (op_q)
			pie_pkg::CH_PLUS:  alu_res = a_q + b_q;
			pie_pkg::CH_MINUS: alu_res = a_q - b_q;
			pie_pkg::CH_MUL:   alu_res = a_q * b_q;
			pie_pkg::CH_XOR:   alu_res = a_q ^ b_q;
			pie_pkg::CH_OR:    alu_res = a_q | b_q;
			default:           alu_res = a_q & b_q;
		endcase
	end

	// sign fix-up: quotient negative when signs differ, remainder follows the dividend
	always_comb begin
		if (op_q == pie_pkg::CH_MOD) begin
			div_res = a_q[pie_pkg::DATA_W-1] ? (pie_pkg::word_t'(0) - div_r) : div_r;
		end else begin
			div_res = (a_q[pie_pkg::DATA_W-1] ^ b_q[pie_pkg::DATA_W-1]) ?
			          (pie_pkg::word_t'(0) - div_q) : div_q;
		end
	end

	// stack requests for this cycle
	always_comb begin
		pop_req   = 1'b0;
		push_req  = 1'b0;
		push_val  = alu_res;
		div_start = 1'b0;
		note_code = pie_pkg::ERR_NONE;
		if (accept) begin
			unique case (mode_q)
				M_NUMBER: begin
					if (is_sp) begin
						push_req = 1'b1;
						push_val = neg_q ? (pie_pkg::word_t'(0) - accum_q) : accum_q;
					end
				end
				M_MINUS: begin
					pop_req = is_sp;
				end
				default: begin
					pop_req = is_nl || is_op;
				end
			endcase
		end
		unique case (state_q)
			S_GETB: begin
				pop_req = 1'b1;
			end
			S_EXEC: begin
				if (!is_divop) begin
					push_req = 1'b1;
				end else if (b_q == '0) begin
					push_req  = 1'b1;
					push_val  = '0;
					note_code = pie_pkg::ERR_DIVZ;
				end else begin
					div_start = 1'b1;
				end
			end
			S_DIVW: begin
				if (div_done) begin
					push_req = 1'b1;
					push_val = div_res;
				end
			end
			default: begin
			end
		endcase
		// a pop and a push never fall in the same cycle
		priority if (pop_req && stack_empty) begin
			note_code = pie_pkg::ERR_UNDER;
		end else if (push_req && stack_full && (note_code == pie_pkg::ERR_NONE)) begin
			note_code = pie_pkg::ERR_OVER;
		end else begin
		end
	end

	assign rd_en     = pop_req && !stack_empty;
	assign wr_en     = push_req && !stack_full;
	assign rd_addr   = count_dec[IDX_W-1:0];
	assign wr_addr   = count_q[IDX_W-1:0];
	assign emit_load = (state_q == S_EMIT) && (!out_valid_q || results.ready);

	// reads and writes never fall in the same cycle, so the same entry is
	// never read and written at once and no bypass is needed
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[wr_addr] <= push_val;
		end
		if (rd_en) begin
			rd_data_q <= store_mem[rd_addr];
		end
	end

	pie_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (mag_a),
		.divisor   (mag_b),
		.done      (div_done),
		.quotient  (div_q),
		.remainder (div_r)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= M_IDLE;
			neg_q       <= 1'b0;
			accum_q     <= '0;
			count_q     <= '0;
			sticky_q    <= pie_pkg::ERR_NONE;
			popped_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rd_en) begin
				count_q <= count_dec;
			end else if (wr_en) begin
				count_q <= count_q + 1'b1;
			end
			if (pop_req) begin
				popped_q <= !stack_empty;
			end
			if ((sticky_q == pie_pkg::ERR_NONE) && (note_code != pie_pkg::ERR_NONE)) begin
				sticky_q <= note_code;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (mode_q)
							M_NUMBER: begin
								if (is_sp) begin
									mode_q <= M_IDLE;
								end else begin
									accum_q <= accum_next;
								end
							end
							M_MINUS: begin
								if (is_sp) begin
									mode_q  <= M_IDLE;
									state_q <= S_GETB;
								end else begin
									accum_q <= digit;
									neg_q   <= 1'b1;
									mode_q  <= M_NUMBER;
								end
							end
							default: begin
								priority if (is_sp) begin
									mode_q <= M_IDLE;
								end else if (is_nl) begin
									state_q <= S_EMIT;
								end else if (c == pie_pkg::CH_MINUS) begin
									mode_q <= M_MINUS;
								end else if (is_op) begin
									state_q <= S_GETB;
								end else begin
									accum_q <= digit;
									neg_q   <= 1'b0;
									mode_q  <= M_NUMBER;
								end
							end
						endcase
					end
				end
				S_GETB: state_q <= S_GETA;
				S_GETA: state_q <= S_EXEC;
				S_EXEC: state_q <= div_start ? S_DIVW : S_IDLE;
				S_DIVW: begin
					if (div_done) begin
						state_q <= S_IDLE;
					end
				end
				S_EMIT: begin
					if (emit_load) begin
						state_q  <= S_IDLE;
						sticky_q <= pie_pkg::ERR_NONE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// operand and result payload
	always_ff @(posedge clk) begin
		if (accept && (state_q == S_IDLE)) begin
			op_q <= (mode_q == M_MINUS) ? pie_pkg::CH_MINUS : c;
		end
		if (state_q == S_GETB) begin
			b_q <= popped_q ? rd_data_q : '0;
		end
		if (state_q == S_GETA) begin
			a_q <= popped_q ? rd_data_q : '0;
		end
		if (emit_load) begin
			out_value_q <= popped_q ? rd_data_q : '0;
			out_err_q   <= sticky_q;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.result_value = out_value_q;
	assign results.error_code   = out_err_q;

endmodule

### rtl/pie_divider.sv
// Unsigned restoring divider, one quotient bit per cycle.
module pie_divider (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  pie_pkg::word_t dividend,
	input  pie_pkg::word_t divisor,
	output logic           done,
	output pie_pkg::word_t quotient,
	output pie_pkg::word_t remainder
);

	localparam int CNT_W = $clog2(pie_pkg::DATA_W + 1);

	pie_pkg::word_t            rem_q;
	pie_pkg::word_t            quo_q;
	pie_pkg::word_t            dvs_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [pie_pkg::DATA_W:0]  shifted;
	logic [pie_pkg::DATA_W:0]  diff;

	assign shifted = {rem_q, quo_q[pie_pkg::DATA_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(pie_pkg::DATA_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			// trial subtract; keep it when no borrow
			if (!diff[pie_pkg::DATA_W]) begin
				rem_q <= diff[pie_pkg::DATA_W-1:0];
			end else begin
				rem_q <= shifted[pie_pkg::DATA_W-1:0];
			end
			quo_q <= {quo_q[pie_pkg::DATA_W-2:0], ~diff[pie_pkg::DATA_W]};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

### rtl/pie_checker.sv
// Port-level checks for the postfix evaluator, bound to the top level.
module pie_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               chars_valid,
	input logic                               chars_ready,
	input logic [pie_pkg::CHAR_W-1:0]         chars_code,
	input logic                               res_valid,
	input logic                               res_ready
);

	// a result beat stays offered until taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result beat dropped before it was taken");

	// a fresh result follows an accepted newline, after its stack read and the load in S_EMIT
	a_res_after_nl: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(chars_valid && chars_ready &&
		                           (chars_code == pie_pkg::CH_NL), 2))
		else $error("result appeared without a preceding newline");

	// the load cycle holds off characters, and the block is free again straight after
	a_res_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> chars_ready && !$past(chars_ready))
		else $error("character acceptance wrong around result load");

endmodule

bind postfix_integer_evaluator_core pie_checker u_pie_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.chars_valid (chars.valid),
	.chars_ready (chars.ready),
	.chars_code  (chars.char_code),
	.res_valid   (results.valid),
	.res_ready   (results.ready)
);
